[design/clti_pkg.sv]
// ----------------------------------------------------------------------------
// clti_pkg
// Shared widths, codes and types of the color LUT interpolation unit.
// ----------------------------------------------------------------------------
package clti_pkg;

  // Value format: signed Q3.16 in 20 bits
  localparam int VAL_W     = 20;
  localparam int FRAC_W    = 16;
  localparam int SCALE_W   = 24;
  localparam int GRID_W    = 13;
  localparam int IDX_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MODE_W    = 2;

  localparam int DEF_MAX_GRID = 33;
  localparam int MAX_CURVE    = 4096;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_BYPASS  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CURVE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LATTICE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LUT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RED     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GREEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BLUE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GREEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_BLUE  = 3'd7;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    val_t red;
    val_t green;
    val_t blue;
  } node_t;

  localparam int NODE_W = 3 * VAL_W;

  // Pick one channel of a node
  function automatic val_t node_chan(input node_t n, input logic [1:0] c);
    val_t v;
    unique case (c)
      2'd0: v = n.red;
      2'd1: v = n.green;
      default: v = n.blue;
    endcase
    return v;
  endfunction

endpackage

[design/clti_if.sv]
// ----------------------------------------------------------------------------
// clti_pix_if / clti_res_if
// Valid/ready channels for input transactions and result transactions.
// ----------------------------------------------------------------------------
interface clti_pix_if import clti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [IDX_W-1:0] node_index;
  val_t             node_red;
  val_t             node_green;
  val_t             node_blue;
  val_t             pix_red;
  val_t             pix_green;
  val_t             pix_blue;

  modport source (output valid, opcode, node_index, node_red, node_green, node_blue,
                  pix_red, pix_green, pix_blue, input ready);
  modport sink   (input valid, opcode, node_index, node_red, node_green, node_blue,
                  pix_red, pix_green, pix_blue, output ready);
endinterface

interface clti_res_if import clti_pkg::*; ();
  logic valid;
  logic ready;
  val_t out_red;
  val_t out_green;
  val_t out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

[design/color_lut_trilinear_interp_unit.sv]
// ----------------------------------------------------------------------------
// color_lut_trilinear_interp_unit
// 3D / 1D color look-up with trilinear or linear interpolation.
// ----------------------------------------------------------------------------
// One transaction enters per clock while result-side back-pressure does not
// hold the pipe, and pixel results leave in order; node writes yield no
// result. The pipeline is set by the two multipliers of the position unit,
// the two address multipliers and three two-stage blend levels. The node
// table is held in eight replicated RAMs, one per lattice corner, so that all
// eight corners are read in the same cycle; writes update all copies at the
// read stage, which keeps reads and writes in order. Unwritten nodes read
// undefined. Write configuration only while the unit is idle.
// ----------------------------------------------------------------------------
module color_lut_trilinear_interp_unit import clti_pkg::*; #(
  parameter int MAX_GRID = DEF_MAX_GRID
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  clti_pix_if.sink              in_ch,
  clti_res_if.source            out_ch
);

  localparam int DEPTH     = MAX_GRID * MAX_GRID * MAX_GRID;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CURVE_LIM = (MAX_CURVE < DEPTH) ? MAX_CURVE : DEPTH;
  localparam int N_ST      = 14;
  localparam int ST_RAM    = 8;

  typedef struct packed {
    logic                          op;
    logic [IDX_W-1:0]              idx;
    node_t                         nval;
    node_t                         pix;
    logic [2:0][FRAC_W-1:0]        f;
    logic [2:0][GRID_W-1:0]        i0;
    logic [2:0][GRID_W-1:0]        i1;
  } side_t;

  // Configuration registers
  logic [MODE_W-1:0]  lut_mode;
  logic [GRID_W-1:0]  grid_size;
  val_t               dom_min   [3];
  logic [SCALE_W-1:0] dom_scale [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      lut_mode  <= MODE_BYPASS;
      grid_size <= GRID_W'(2);
      for (int c = 0; c < 3; c++) begin
        dom_min[c]   <= '0;
        dom_scale[c] <= SCALE_W'(65536);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LUT_MODE:    lut_mode     <= cfg_data[MODE_W-1:0];
        REG_GRID_SIZE:   grid_size    <= cfg_data[GRID_W-1:0];
        REG_MIN_RED:     dom_min[0]   <= cfg_data[VAL_W-1:0];
        REG_MIN_GREEN:   dom_min[1]   <= cfg_data[VAL_W-1:0];
        REG_MIN_BLUE:    dom_min[2]   <= cfg_data[VAL_W-1:0];
        REG_SCALE_RED:   dom_scale[0] <= cfg_data[SCALE_W-1:0];
        REG_SCALE_GREEN: dom_scale[1] <= cfg_data[SCALE_W-1:0];
        REG_SCALE_BLUE:  dom_scale[2] <= cfg_data[SCALE_W-1:0];
      endcase
    end
  end

  logic is_curve;
  logic is_interp;
  assign is_curve  = (lut_mode == MODE_CURVE);
  assign is_interp = (lut_mode == MODE_CURVE) || (lut_mode == MODE_LATTICE);

  // Effective grid size: 2 outside the interpolating modes, else clamped to between 2 and the mode's limit
  int                lim;
  int                s_int;
  logic [GRID_W-1:0] s;
  logic [GRID_W-1:0] s_m1;

  always_comb begin
    lim = (lut_mode == MODE_LATTICE) ? MAX_GRID : CURVE_LIM;
    if (!is_interp || (int'(grid_size) < 2)) begin
      s_int = 2;
    end else if (int'(grid_size) > lim) begin
      s_int = lim;
    end else begin
      s_int = int'(grid_size);
    end
    s    = GRID_W'(s_int);
    s_m1 = s - GRID_W'(1);
  end

  // Stage handshake: a stage loads when empty or when its successor loads
  logic [N_ST+1:1] en;
  logic [N_ST:1]   v;
  side_t           side [1:N_ST];

  always_comb begin
    en[N_ST+1] = out_ch.ready;
    for (int k = N_ST; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[1];

  // Advance valid bits; writes leave the pipe after the RAM stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= in_ch.valid;
      end
      for (int k = 2; k <= N_ST; k++) begin
        if (en[k]) begin
          if (k == ST_RAM + 1) begin
            v[k] <= v[k-1] && (side[k-1].op == OP_EVAL);
          end else begin
            v[k] <= v[k-1];
          end
        end
      end
    end
  end

  // Position units, stages 2 to 5
  logic [GRID_W-1:0] loc_i0 [3];
  logic [GRID_W-1:0] loc_i1 [3];
  logic [FRAC_W-1:0] loc_f  [3];
  val_t              pix_ch [3];

  assign pix_ch[0] = side[1].pix.red;
  assign pix_ch[1] = side[1].pix.green;
  assign pix_ch[2] = side[1].pix.blue;

  for (genvar c = 0; c < 3; c++) begin : g_loc
    clti_locate u_loc (
      .clk       (clk),
      .en        (en[5:2]),
      .pix       (pix_ch[c]),
      .dom_min   (dom_min[c]),
      .dom_scale (dom_scale[c]),
      .size_m1   (s_m1),
      .i0        (loc_i0[c]),
      .i1        (loc_i1[c]),
      .frac      (loc_f[c])
    );
  end

  // Carry side data; take the position results at stage 6
  always_ff @(posedge clk) begin
    if (en[1]) begin
      side[1].op        <= in_ch.opcode;
      side[1].idx       <= in_ch.node_index;
      side[1].nval      <= '{in_ch.node_red, in_ch.node_green, in_ch.node_blue};
      side[1].pix       <= '{in_ch.pix_red, in_ch.pix_green, in_ch.pix_blue};
      side[1].f         <= '0;
      side[1].i0        <= '0;
      side[1].i1        <= '0;
    end
    for (int k = 2; k <= N_ST; k++) begin
      if (en[k]) begin
        if (k == 6) begin
          side[k].op   <= side[k-1].op;
          side[k].idx  <= side[k-1].idx;
          side[k].nval <= side[k-1].nval;
          side[k].pix  <= side[k-1].pix;
          for (int c = 0; c < 3; c++) begin
            side[k].i0[c] <= loc_i0[c];
            side[k].i1[c] <= loc_i1[c];
            side[k].f[c]  <= loc_f[c];
          end
        end else begin
          side[k] <= side[k-1];
        end
      end
    end
  end

  // Lattice row addresses: blue times size, then plus green, all times size
  localparam int BS_W  = 2 * GRID_W;
  localparam int ROW_W = BS_W + 1 + GRID_W;

  logic [BS_W-1:0]   bs  [2];
  logic [ADDR_W-1:0] row [4];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      bs[0] <= BS_W'(loc_i0[2]) * BS_W'(s);
      bs[1] <= BS_W'(loc_i1[2]) * BS_W'(s);
    end
    if (en[7]) begin
      for (int j = 0; j < 4; j++) begin
        row[j] <= ADDR_W'((ROW_W'(bs[j/2]) + ROW_W'((j % 2 == 1) ? side[6].i1[1] :
                                                    side[6].i0[1])) * ROW_W'(s));
      end
    end
  end

  // Corner addresses: pairs of lower and upper red nodes per row, or per channel in curve mode
  logic [ADDR_W-1:0] raddr [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (!is_curve) begin
        raddr[k] = row[k/2] + ADDR_W'((k % 2 == 1) ? side[7].i1[0] : side[7].i0[0]);
      end else if (k < 6) begin
        raddr[k] = ADDR_W'((k % 2 == 1) ? side[7].i1[k/2] : side[7].i0[k/2]);
      end else begin
        raddr[k] = '0;
      end
    end
  end

  // Node writes update every copy at the read stage
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;

  assign tbl_we    = en[ST_RAM] && v[ST_RAM-1] && (side[ST_RAM-1].op == OP_WRITE) &&
                     (32'(side[ST_RAM-1].idx) < DEPTH);
  assign tbl_waddr = ADDR_W'(side[ST_RAM-1].idx);

  node_t rd [8];

  for (genvar k = 0; k < 8; k++) begin : g_tbl
    clti_ram #(
      .WIDTH (NODE_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (side[ST_RAM-1].nval),
      .re    (en[ST_RAM]),
      .raddr (raddr[k]),
      .rdata (rd[k])
    );
  end

  // Red blend level, stages 9 and 10
  logic [FRAC_W-1:0] f_r [4];
  val_t              y_r [4][3];

  for (genvar p = 0; p < 4; p++) begin : g_fr
    if (p < 3) begin : g_own
      assign f_r[p] = is_curve ? side[ST_RAM].f[p] : side[ST_RAM].f[0];
    end else begin : g_red
      assign f_r[p] = side[ST_RAM].f[0];
    end
    for (genvar c = 0; c < 3; c++) begin : g_ch
      clti_lerp u_lerp (
        .clk (clk),
        .en  (en[10:9]),
        .a   (node_chan(rd[2*p], 2'(c))),
        .b   (node_chan(rd[2*p+1], 2'(c))),
        .f   (f_r[p]),
        .y   (y_r[p][c])
      );
    end
  end

  // Gather curve results into the first row; later levels pass them on
  val_t m_r [4][3];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 3; c++) begin
        m_r[p][c] = (is_curve && (p == 0)) ? y_r[c][c] : y_r[p][c];
      end
    end
  end

  // Green blend level, stages 11 and 12
  logic [FRAC_W-1:0] f_g;
  val_t              y_g [2][3];

  assign f_g = is_curve ? '0 : side[10].f[1];

  for (genvar q = 0; q < 2; q++) begin : g_gl
    for (genvar c = 0; c < 3; c++) begin : g_ch
      clti_lerp u_lerp (
        .clk (clk),
        .en  (en[12:11]),
        .a   (m_r[2*q][c]),
        .b   (m_r[2*q+1][c]),
        .f   (f_g),
        .y   (y_g[q][c])
      );
    end
  end

  // Blue blend level, stages 13 and 14
  logic [FRAC_W-1:0] f_b;
  val_t              y_b [3];

  assign f_b = is_curve ? '0 : side[12].f[2];

  for (genvar c = 0; c < 3; c++) begin : g_bl
    clti_lerp u_lerp (
      .clk (clk),
      .en  (en[14:13]),
      .a   (y_g[0][c]),
      .b   (y_g[1][c]),
      .f   (f_b),
      .y   (y_b[c])
    );
  end

  // Drive the result channel; bypass and the unused mode code return the pixel unchanged
  assign out_ch.valid     = v[N_ST];
  assign out_ch.out_red   = is_interp ? y_b[0] : side[N_ST].pix.red;
  assign out_ch.out_green = is_interp ? y_b[1] : side[N_ST].pix.green;
  assign out_ch.out_blue  = is_interp ? y_b[2] : side[N_ST].pix.blue;

endmodule

[design/clti_ram.sv]
// ----------------------------------------------------------------------------
// clti_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module clti_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/clti_locate.sv]
// ----------------------------------------------------------------------------
// clti_locate
// Four-stage position unit for one channel: offset, scale, grid scale,
// split into lower node, upper node and fraction.
// ----------------------------------------------------------------------------
module clti_locate import clti_pkg::*; (
  input  logic               clk,
  input  logic [3:0]         en,
  input  val_t               pix,
  input  val_t               dom_min,
  input  logic [SCALE_W-1:0] dom_scale,
  input  logic [GRID_W-1:0]  size_m1,
  output logic [GRID_W-1:0]  i0,
  output logic [GRID_W-1:0]  i1,
  output logic [FRAC_W-1:0]  frac
);

  localparam int D_W = VAL_W + 1;
  localparam int P_W = D_W + SCALE_W + 1;
  localparam int U_W = FRAC_W + 1;
  localparam int X_W = U_W + GRID_W;
  localparam logic [U_W-1:0] ONE = U_W'(1) << FRAC_W;

  logic signed [D_W-1:0] d;
  logic signed [P_W-1:0] p;
  logic signed [P_W-1:0] p_sh;
  logic [U_W-1:0]        u;
  logic [X_W-1:0]        x;
  logic [X_W-FRAC_W-1:0] x_int;

  // Offset by the domain minimum
  always_ff @(posedge clk) begin
    if (en[0]) begin
      d <= D_W'(pix) - D_W'(dom_min);
    end
  end

  // Multiply by the reciprocal span
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p <= P_W'(d) * $signed({1'b0, dom_scale});
    end
  end

  // Clamp to [0,1] and scale by the grid
  always_comb begin
    p_sh = p >>> FRAC_W;
    if (p <= 0) begin
      u = '0;
    end else if (p_sh > P_W'(ONE)) begin
      u = ONE;
    end else begin
      u = U_W'(p_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x <= X_W'(u) * X_W'(size_m1);
    end
  end

  // Split into node index and fraction; the top node has zero fraction
  assign x_int = x[X_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (x_int >= (X_W-FRAC_W)'(size_m1)) begin
        i0   <= size_m1;
        i1   <= size_m1;
        frac <= '0;
      end else begin
        i0   <= GRID_W'(x_int);
        i1   <= GRID_W'(x_int) + GRID_W'(1);
        frac <= x[FRAC_W-1:0];
      end
    end
  end

endmodule

[design/clti_lerp.sv]
// ----------------------------------------------------------------------------
// clti_lerp
// Two-stage linear blend: a + floor((b - a) * f / 2^FRAC_W).
// ----------------------------------------------------------------------------
module clti_lerp import clti_pkg::*; (
  input  logic              clk,
  input  logic [1:0]        en,
  input  val_t              a,
  input  val_t              b,
  input  logic [FRAC_W-1:0] f,
  output val_t              y
);

  localparam int DIF_W  = VAL_W + 1;
  localparam int PROD_W = DIF_W + FRAC_W + 1;

  logic signed [DIF_W-1:0]  dif;
  logic signed [PROD_W-1:0] prod;
  val_t                     a_q;

  assign dif = DIF_W'(b) - DIF_W'(a);

  // Weighted difference
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_q  <= a;
      prod <= PROD_W'(dif) * $signed({1'b0, f});
    end
  end

  // Add the floored step; the result lies between a and b
  always_ff @(posedge clk) begin
    if (en[1]) begin
      y <= VAL_W'(PROD_W'(a_q) + (prod >>> FRAC_W));
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the color LUT interpolation unit. A directed table
// covers bypass, the unknown mode, ignored writes, lattice corners and the
// register extremes. Random phases follow, each with its own configuration.
// Pixels are predicted from a local copy of the node table and registers, or
// given by the directed row; nodes that a pixel reads are loaded first if needed.
// ----------------------------------------------------------------------------
module tb_top;
  import clti_pkg::*;

  localparam int TBL_DEPTH = DEF_MAX_GRID * DEF_MAX_GRID * DEF_MAX_GRID;
  localparam int DRAIN_CYC = 20;

  typedef enum logic [1:0] {K_REG, K_NODE, K_PIX} kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [CFG_IDX_W-1:0]  ridx;
    logic [CFG_DATA_W-1:0] rdata;
    logic [IDX_W-1:0]      nidx;
    node_t                 val;
    logic                  typed;
    node_t                 want;
  } row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  clti_pix_if pix_ch ();
  clti_res_if res_ch ();

  color_lut_trilinear_interp_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (pix_ch),
    .out_ch    (res_ch)
  );

  // Local copy of the unit's registers and node table
  logic [MODE_W-1:0]  lut_mode;
  logic [GRID_W-1:0]  grid_size;
  val_t               dom_min [3];
  logic [SCALE_W-1:0] dom_scale [3];
  node_t              lut_mem [TBL_DEPTH];
  bit                 loaded [TBL_DEPTH];

  node_t  color_q [$];
  int     err_cnt;
  int     mism_cnt;
  int     n_sent;
  bit     send_calm;
  bit     recv_calm;

  // Directed stimulus table
  row_t dir_rows [0:28] = '{
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b1, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sh7FFFF, 20'sh80000, 20'shFFFFF},
      1'b1, '{20'sh7FFFF, 20'sh80000, 20'shFFFFF}},
    '{K_REG, REG_LUT_MODE, 24'd3, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sd12345, 20'shFFFF9, 20'sd65536},
      1'b1, '{20'sd12345, 20'shFFFF9, 20'sd65536}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'hFFFF, '{20'sd1, 20'sd2, 20'sd3},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd35937, '{20'sd4, 20'sd5, 20'sd6},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_REG, REG_LUT_MODE, 24'd2, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_REG, REG_GRID_SIZE, 24'd0, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd0, '{20'sh80000, 20'sh7FFFF, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd1, '{20'sd1000, 20'sd2000, 20'sd3000},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd2, '{20'sd65536, 20'shF0000, 20'sd7},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd3, '{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd4, '{20'sh80000, 20'sh80000, 20'sh80000},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd5, '{20'sd32768, 20'sd0, 20'shFFFFF},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd6, '{20'sd5, 20'sd99999, 20'sh81234},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_NODE, REG_LUT_MODE, 24'd0, 16'd7, '{20'sh7FFFF, 20'sh80000, 20'sd1},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b1, '{20'sh80000, 20'sh7FFFF, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sd65536, 20'sd65536, 20'sd65536},
      1'b1, '{20'sh7FFFF, 20'sh80000, 20'sd1}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sd32768, 20'sd16384, 20'sd49152},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sh80000, 20'sh80000, 20'sh80000},
      1'b1, '{20'sh80000, 20'sh7FFFF, 20'sd0}},
    '{K_REG, REG_SCALE_RED, 24'hFFFFFF, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_REG, REG_MIN_RED, 24'h080000, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sh80001, 20'sd100, 20'sd60000},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_REG, REG_SCALE_GREEN, 24'd1, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sh80000, 20'sh7FFFF, 20'sd30000},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_REG, REG_GRID_SIZE, 24'd4096, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sh80100, 20'sd40000, 20'sd65535},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_REG, REG_LUT_MODE, 24'd1, 16'd0, '{20'sd0, 20'sd0, 20'sd0},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}},
    '{K_PIX, REG_LUT_MODE, 24'd0, 16'd0, '{20'sh7FFFF, 20'sh7FFFF, 20'sd12345},
      1'b0, '{20'sd0, 20'sd0, 20'sd0}}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #50_000_000;
    $display("FAIL color_lut_trilinear_interp_unit");
    $finish;
  end

  // Draw a per-transaction wait, with occasional stretches of none
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic longint chan_of(input int adr, input int c);
    case (c)
      0: return longint'(lut_mem[adr].red);
      1: return longint'(lut_mem[adr].green);
      default: return longint'(lut_mem[adr].blue);
    endcase
  endfunction

  function automatic val_t pix_chan(input node_t v, input int c);
    case (c)
      0: return v.red;
      1: return v.green;
      default: return v.blue;
    endcase
  endfunction

  // Axis size in use for the current mode
  function automatic int axis_size();
    int s;
    if (lut_mode == MODE_CURVE || lut_mode == MODE_LATTICE) begin
      s = int'(grid_size);
      if (s < 2) s = 2;
      if (lut_mode == MODE_LATTICE && s > DEF_MAX_GRID) s = DEF_MAX_GRID;
      if (lut_mode == MODE_CURVE && s > MAX_CURVE) s = MAX_CURVE;
      return s;
    end
    return 2;
  endfunction

  // Normalize one channel and find its two neighbor nodes and fraction
  function automatic void find_pos(input val_t px, input int c, input int s,
                                   output int i0, output int i1, output longint f);
    longint p;
    longint u;
    longint x;
    p = (longint'(px) - longint'(dom_min[c])) * longint'({1'b0, dom_scale[c]});
    if (p <= 0) u = 0;
    else begin
      u = p >>> FRAC_W;
      if (u > 65536) u = 65536;
    end
    x = u * longint'(s - 1);
    i0 = int'(x >>> FRAC_W);
    f = x & 64'hFFFF;
    if (i0 >= s - 1) begin
      i0 = s - 1;
      i1 = i0;
      f = 0;
    end else begin
      i1 = i0 + 1;
    end
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint f);
    return a + (((b - a) * f) >>> FRAC_W);
  endfunction

  function automatic val_t clip(input longint v);
    if (v > 524287) return 20'sh7FFFF;
    if (v < -524288) return 20'sh80000;
    return val_t'(v);
  endfunction

  // Node addresses that one pixel reads in the current mode
  function automatic void pixel_nodes(input node_t v, output int adr [8], output int n);
    int s;
    int lo [3];
    int hi [3];
    longint f;
    s = axis_size();
    n = 0;
    for (int c = 0; c < 3; c++) find_pos(pix_chan(v, c), c, s, lo[c], hi[c], f);
    if (lut_mode == MODE_LATTICE) begin
      for (int k = 0; k < 8; k++) begin
        adr[k] = ((((k & 4) ? hi[2] : lo[2]) * s + ((k & 2) ? hi[1] : lo[1])) * s)
                 + ((k & 1) ? hi[0] : lo[0]);
      end
      n = 8;
    end else if (lut_mode == MODE_CURVE) begin
      for (int c = 0; c < 3; c++) begin
        adr[2 * c] = lo[c];
        adr[2 * c + 1] = hi[c];
      end
      n = 6;
    end
  endfunction

  // Expected color for one pixel
  function automatic node_t color_of(input node_t v);
    int s;
    int lo [3];
    int hi [3];
    longint fr [3];
    longint cc [4];
    longint res [3];
    int rb;
    s = axis_size();
    for (int c = 0; c < 3; c++) find_pos(pix_chan(v, c), c, s, lo[c], hi[c], fr[c]);
    for (int c = 0; c < 3; c++) begin
      if (lut_mode == MODE_CURVE) begin
        res[c] = blend(chan_of(lo[c], c), chan_of(hi[c], c), fr[c]);
      end else if (lut_mode == MODE_LATTICE) begin
        for (int k = 0; k < 4; k++) begin
          rb = (((k & 2) ? hi[2] : lo[2]) * s + ((k & 1) ? hi[1] : lo[1])) * s;
          cc[k] = blend(chan_of(rb + lo[0], c), chan_of(rb + hi[0], c), fr[0]);
        end
        res[c] = blend(blend(cc[0], cc[1], fr[1]), blend(cc[2], cc[3], fr[1]), fr[2]);
      end else begin
        res[c] = longint'(pix_chan(v, c));
      end
    end
    return '{clip(res[0]), clip(res[1]), clip(res[2])};
  endfunction

  // Write one register; the unit must be idle
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_LUT_MODE:    lut_mode = d[MODE_W-1:0];
      REG_GRID_SIZE:   grid_size = d[GRID_W-1:0];
      REG_MIN_RED:     dom_min[0] = d[VAL_W-1:0];
      REG_MIN_GREEN:   dom_min[1] = d[VAL_W-1:0];
      REG_MIN_BLUE:    dom_min[2] = d[VAL_W-1:0];
      REG_SCALE_RED:   dom_scale[0] = d;
      REG_SCALE_GREEN: dom_scale[1] = d;
      default:         dom_scale[2] = d;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait until every expected color has arrived, then let the pipe settle
  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (color_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  // Send one transaction and predict it when accepted
  task automatic send(input logic op, input logic [IDX_W-1:0] ni, input node_t v,
                      input bit typed, input node_t want);
    int g;
    g = draw_gap(send_calm);
    if (g > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    pix_ch.valid      <= 1'b1;
    pix_ch.opcode     <= op;
    pix_ch.node_index <= ni;
    pix_ch.node_red   <= v.red;
    pix_ch.node_green <= v.green;
    pix_ch.node_blue  <= v.blue;
    pix_ch.pix_red    <= v.red;
    pix_ch.pix_green  <= v.green;
    pix_ch.pix_blue   <= v.blue;
    do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
    n_sent++;
    if (op == OP_WRITE) begin
      if (int'(ni) < TBL_DEPTH) begin
        lut_mem[ni] = v;
        loaded[ni] = 1'b1;
      end
    end else begin
      color_q.push_back(typed ? want : color_of(v));
    end
    @(negedge clk);
  endtask

  function automatic node_t rand_node();
    return '{val_t'($urandom), val_t'($urandom), val_t'($urandom)};
  endfunction

  // Evaluate one pixel, loading any node it reads that was never written
  task automatic eval_pixel(input node_t v);
    int adr [8];
    int n;
    pixel_nodes(v, adr, n);
    for (int k = 0; k < n; k++) begin
      if (!loaded[adr[k]]) send(OP_WRITE, IDX_W'(adr[k]), rand_node(), 1'b0, '0);
    end
    send(OP_EVAL, '0, v, 1'b0, '0);
  endtask

  // Pixel near the active domain of each channel, or anywhere
  function automatic node_t rand_pixel();
    val_t pv [3];
    longint span;
    longint p;
    for (int c = 0; c < 3; c++) begin
      span = (longint'(1) << 32) / longint'({1'b0, dom_scale[c]});
      if (span > 1048576) span = 1048576;
      if ($urandom_range(0, 9) < 7) begin
        p = longint'(dom_min[c]) - span / 8
            + longint'($urandom_range(0, int'(span + span / 4)));
        pv[c] = clip(p);
      end else begin
        pv[c] = val_t'($urandom);
      end
    end
    return '{pv[0], pv[1], pv[2]};
  endfunction

  // Pick and load a random configuration
  task automatic rand_config();
    logic [CFG_DATA_W-1:0] d;
    int m;
    m = $urandom_range(0, 9);
    d = (m < 4) ? CFG_DATA_W'(MODE_LATTICE) : (m < 8) ? CFG_DATA_W'(MODE_CURVE) :
        (m < 9) ? CFG_DATA_W'(MODE_BYPASS) : CFG_DATA_W'(3);
    cfg_put(REG_LUT_MODE, (CFG_DATA_W'($urandom) & ~24'h3) | d);
    case ($urandom_range(0, 9))
      0: d = 24'd0;
      1: d = 24'd1;
      2: d = 24'd4096;
      3: d = 24'h1FFF;
      4: d = 24'd33;
      default: d = (d[1:0] == MODE_CURVE) ? CFG_DATA_W'($urandom_range(2, 64)) :
                                            CFG_DATA_W'($urandom_range(2, 5));
    endcase
    cfg_put(REG_GRID_SIZE, d);
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 7))
        0: d = 24'h080000;
        1: d = 24'h07FFFF;
        2: d = CFG_DATA_W'($urandom);
        default: d = {4'($urandom), 20'($urandom_range(0, 131072) - 65536)};
      endcase
      cfg_put(REG_MIN_RED + CFG_IDX_W'(c), d);
    end
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 7))
        0: d = 24'd1;
        1: d = 24'hFFFFFF;
        2: d = 24'($urandom) | 24'd1;
        default: d = CFG_DATA_W'($urandom_range(16384, 262144));
      endcase
      cfg_put(REG_SCALE_RED + CFG_IDX_W'(c), d);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    node_t got;
    node_t exp_c;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.out_red, res_ch.out_green, res_ch.out_blue};
      if (color_q.size() == 0) begin
        err_cnt++;
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected result %h %h %h", got.red, got.green, got.blue);
      end else begin
        exp_c = color_q.pop_front();
        if (got !== exp_c) begin
          err_cnt++;
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("color mismatch: exp %h %h %h got %h %h %h", exp_c.red, exp_c.green,
                     exp_c.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  // Result-side backpressure
  initial begin
    int g;
    res_ch.ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      g = draw_gap(recv_calm);
      if (g > 0) begin
        res_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int m;
    logic [IDX_W-1:0] ni;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.opcode = OP_WRITE;
    pix_ch.node_index = '0;
    pix_ch.node_red = '0;
    pix_ch.node_green = '0;
    pix_ch.node_blue = '0;
    pix_ch.pix_red = '0;
    pix_ch.pix_green = '0;
    pix_ch.pix_blue = '0;
    err_cnt   = 0;
    mism_cnt  = 0;
    n_sent    = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    lut_mode  = MODE_BYPASS;
    grid_size = 13'd2;
    for (int c = 0; c < 3; c++) begin
      dom_min[c] = '0;
      dom_scale[c] = 24'd65536;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        K_REG: begin
          drain();
          cfg_put(dir_rows[i].ridx, dir_rows[i].rdata);
        end
        K_NODE: send(OP_WRITE, dir_rows[i].nidx, dir_rows[i].val, 1'b0, '0);
        default: begin
          if (dir_rows[i].typed) send(OP_EVAL, '0, dir_rows[i].val, 1'b1, dir_rows[i].want);
          else eval_pixel(dir_rows[i].val);
        end
      endcase
    end

    // Random phases, each under its own configuration
    for (int ph = 0; ph < 13; ph++) begin
      drain();
      rand_config();
      while (n_sent < (ph + 1) * 73) begin
        m = $urandom_range(0, 19);
        if (m < 2) begin
          ni = (axis_size() ** ((lut_mode == MODE_LATTICE) ? 3 : 1) > 1) ?
               IDX_W'($urandom_range(0, 7)) : '0;
          send(OP_WRITE, ni, rand_node(), 1'b0, '0);
        end else if (m < 3) begin
          ni = IDX_W'($urandom);
          send(OP_WRITE, ni, rand_node(), 1'b0, '0);
        end else begin
          eval_pixel(rand_pixel());
        end
        // Hold off until the pipe is empty now and then
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("PASS color_lut_trilinear_interp_unit");
    end else begin
      $display("FAIL color_lut_trilinear_interp_unit");
    end
    $finish;
  end

endmodule

[color_lut_trilinear_interp_unit.f]
design/clti_pkg.sv
design/clti_if.sv
design/clti_ram.sv
design/clti_locate.sv
design/clti_lerp.sv
design/color_lut_trilinear_interp_unit.sv
tb/sv/tb_top.sv
